FILE: rtl/chi_pkg.sv
// shared types and constants of the two-table cuckoo insert block
package chi_pkg;

   // controller states
   typedef enum logic [3:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_REM,
      ST_IDX,
      ST_ISSUE,
      ST_PROBE,
      ST_UNDO,
      ST_UNDO_LAST,
      ST_FINISH
   } chi_state_type;

   // hash divisors, each one less than a power of two
   localparam int HASH0_DIV = 127;
   localparam int HASH1_DIV = 255;
   localparam int HASH0_DIGIT = 7;
   localparam int HASH1_DIGIT = 8;

   // inverses of the divisors modulo 2^10, exact for the low ten quotient bits
   localparam logic [15:0] HASH0_INV = 16'd895;
   localparam logic [15:0] HASH1_INV = 16'd767;

endpackage

FILE: rtl/cuckoo_hash_insert.sv
// top level of the two-table cuckoo insert block
//
// Inserts one nonzero key per transfer into two tables of TABLE_DEPTH keys
// (TABLE_DEPTH a power of two), answering inserted=1 when the key found a
// home and 0 when the insert failed (tables left exactly as before) or the
// key was zero. After reset the block sweeps both tables to empty, one
// entry a cycle, and req_ready stays low until the sweep is done. Each
// insert then hashes the key, issues the first read and probes slots,
// alternating tables: the read of one table overlaps the write-back of the
// other, so the displacement chain runs at one table access a cycle. Each
// table entry keeps its key with the key's slot in the other table, so a
// displaced key needs no rehash. A failure walks the undo log newest
// first, one restore a cycle, and a last step restores the final log read.
// A successful insert makes at most 2*MAX_ROUNDS probes. Each result then
// moves into the output register once that is free; the register holds it
// while the next key is accepted.
module cuckoo_hash_insert #(
   parameter int TABLE_DEPTH = 128,
   parameter int MAX_ROUNDS  = 10,
   parameter int KEY_BITS    = 48
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_ready,
   input  logic [KEY_BITS-1:0] req_key,
   output logic                rsp_valid,
   input  logic                rsp_ready,
   output logic                rsp_inserted
);

   localparam int IDX_BITS   = $clog2(TABLE_DEPTH);
   localparam int ENTRY_BITS = KEY_BITS + IDX_BITS;
   localparam int LOG_DEPTH  = 2 * MAX_ROUNDS;
   localparam int LOG_BITS   = $clog2(LOG_DEPTH);
   localparam int LOG_WIDTH  = IDX_BITS + ENTRY_BITS;
   localparam logic [LOG_BITS-1:0] LOG_LAST = LOG_BITS'(LOG_DEPTH - 1);
   localparam logic [IDX_BITS-1:0] CLR_LAST = IDX_BITS'(TABLE_DEPTH - 1);

   chi_pkg::chi_state_type state_ff, state_in;

   // item being carried along the displacement chain
   logic [KEY_BITS-1:0] cur_key_ff, cur_key_in;
   logic [IDX_BITS-1:0] cur_idx_ff, cur_idx_in;   // slot in the table probed now
   logic [IDX_BITS-1:0] cur_aux_ff, cur_aux_in;   // its slot in the other table
   logic [LOG_BITS-1:0] probe_ff, probe_in;       // probe number, low bit is the side
   logic [LOG_BITS-1:0] undo_ff, undo_in;         // undo log read pointer
   logic                pend_ff, pend_in;         // log read data waits to be restored
   logic                wside_ff, wside_in;       // table of the pending restore
   logic [IDX_BITS-1:0] clr_ff, clr_in;
   logic                res_ff, res_in;
   logic                rsp_valid_ff, rsp_valid_in;
   logic                rsp_inserted_ff, rsp_inserted_in;

   // table and log ports
   logic                  t0_we, t0_re, t1_we, t1_re;
   logic [IDX_BITS-1:0]   t0_wa, t0_ra, t1_wa, t1_ra;
   logic [ENTRY_BITS-1:0] t0_wd, t0_rd, t1_wd, t1_rd;
   logic                  lg_we, lg_re;
   logic [LOG_BITS-1:0]   lg_wa, lg_ra;
   logic [LOG_WIDTH-1:0]  lg_wd, lg_rd;

   logic [IDX_BITS-1:0]   h_idx0, h_idx1;
   logic [ENTRY_BITS-1:0] probe_rd;
   logic [KEY_BITS-1:0]   old_key;
   logic [IDX_BITS-1:0]   old_aux;
   logic                  restore_en;

   chi_hash #(
      .KEY_BITS(KEY_BITS),
      .IDX_BITS(IDX_BITS)
   ) u_hash (
      .clock(clock),
      .key  (cur_key_ff),
      .idx0 (h_idx0),
      .idx1 (h_idx1)
   );

   chi_ram #(
      .DEPTH(TABLE_DEPTH),
      .WIDTH(ENTRY_BITS)
   ) u_table0 (
      .clock  (clock),
      .wr_en  (t0_we),
      .wr_addr(t0_wa),
      .wr_data(t0_wd),
      .rd_en  (t0_re),
      .rd_addr(t0_ra),
      .rd_data(t0_rd)
   );

   chi_ram #(
      .DEPTH(TABLE_DEPTH),
      .WIDTH(ENTRY_BITS)
   ) u_table1 (
      .clock  (clock),
      .wr_en  (t1_we),
      .wr_addr(t1_wa),
      .wr_data(t1_wd),
      .rd_en  (t1_re),
      .rd_addr(t1_ra),
      .rd_data(t1_rd)
   );

   // undo log: slot written and the entry it held
   chi_ram #(
      .DEPTH(LOG_DEPTH),
      .WIDTH(LOG_WIDTH)
   ) u_undo_log (
      .clock  (clock),
      .wr_en  (lg_we),
      .wr_addr(lg_wa),
      .wr_data(lg_wd),
      .rd_en  (lg_re),
      .rd_addr(lg_ra),
      .rd_data(lg_rd)
   );

   // occupant of the slot probed this cycle
   assign probe_rd = probe_ff[0] ? t1_rd : t0_rd;
   assign old_key  = probe_rd[ENTRY_BITS-1:IDX_BITS];
   assign old_aux  = probe_rd[IDX_BITS-1:0];

   assign restore_en = ((state_ff == chi_pkg::ST_UNDO) && pend_ff) ||
                       (state_ff == chi_pkg::ST_UNDO_LAST);

   always_comb begin
      state_in        = state_ff;
      cur_key_in      = cur_key_ff;
      cur_idx_in      = cur_idx_ff;
      cur_aux_in      = cur_aux_ff;
      probe_in        = probe_ff;
      undo_in         = undo_ff;
      pend_in         = pend_ff;
      wside_in        = wside_ff;
      clr_in          = clr_ff;
      res_in          = res_ff;
      rsp_valid_in    = rsp_valid_ff;
      rsp_inserted_in = rsp_inserted_ff;

      t0_we = 1'b0;
      t0_wa = cur_idx_ff;
      t0_wd = {cur_key_ff, cur_aux_ff};
      t0_re = 1'b0;
      t0_ra = old_aux;
      t1_we = 1'b0;
      t1_wa = cur_idx_ff;
      t1_wd = {cur_key_ff, cur_aux_ff};
      t1_re = 1'b0;
      t1_ra = old_aux;
      lg_we = 1'b0;
      lg_wa = probe_ff;
      lg_wd = {cur_idx_ff, probe_rd};
      lg_re = 1'b0;
      lg_ra = undo_ff;

      // output register drains on its own transfer
      if (rsp_valid_ff && rsp_ready) begin
         rsp_valid_in = 1'b0;
      end

      // restore of a logged entry, newest first
      if (restore_en) begin
         if (wside_ff) begin
            t1_we = 1'b1;
            t1_wa = lg_rd[LOG_WIDTH-1:ENTRY_BITS];
            t1_wd = lg_rd[ENTRY_BITS-1:0];
         end else begin
            t0_we = 1'b1;
            t0_wa = lg_rd[LOG_WIDTH-1:ENTRY_BITS];
            t0_wd = lg_rd[ENTRY_BITS-1:0];
         end
      end

      case (state_ff)
         chi_pkg::ST_CLEAR: begin
            t0_we  = 1'b1;
            t0_wa  = clr_ff;
            t0_wd  = '0;
            t1_we  = 1'b1;
            t1_wa  = clr_ff;
            t1_wd  = '0;
            clr_in = clr_ff + 1'b1;
            if (clr_ff == CLR_LAST) begin
               state_in = chi_pkg::ST_IDLE;
            end
         end
         chi_pkg::ST_IDLE: begin
            if (req_valid) begin
               if (req_key == '0) begin
                  // zero is the empty mark, rejected without touching the tables
                  res_in   = 1'b0;
                  state_in = chi_pkg::ST_FINISH;
               end else begin
                  cur_key_in = req_key;
                  state_in   = chi_pkg::ST_REM;
               end
            end
         end
         chi_pkg::ST_REM: begin
            state_in = chi_pkg::ST_IDX;
         end
         chi_pkg::ST_IDX: begin
            state_in = chi_pkg::ST_ISSUE;
         end
         chi_pkg::ST_ISSUE: begin
            t0_re      = 1'b1;
            t0_ra      = h_idx0;
            cur_idx_in = h_idx0;
            cur_aux_in = h_idx1;
            probe_in   = '0;
            state_in   = chi_pkg::ST_PROBE;
         end
         chi_pkg::ST_PROBE: begin
            // write the carried key over the slot just read
            if (probe_ff[0]) begin
               t1_we = 1'b1;
            end else begin
               t0_we = 1'b1;
            end
            if (old_key == '0) begin
               res_in   = 1'b1;
               state_in = chi_pkg::ST_FINISH;
            end else begin
               lg_we      = 1'b1;
               cur_key_in = old_key;
               cur_aux_in = cur_idx_ff;
               cur_idx_in = old_aux;
               if (probe_ff == LOG_LAST) begin
                  undo_in  = LOG_LAST;
                  pend_in  = 1'b0;
                  state_in = chi_pkg::ST_UNDO;
               end else begin
                  // evicted key goes to its slot in the other table
                  probe_in = probe_ff + 1'b1;
                  if (probe_ff[0]) begin
                     t0_re = 1'b1;
                  end else begin
                     t1_re = 1'b1;
                  end
               end
            end
         end
         chi_pkg::ST_UNDO: begin
            lg_re    = 1'b1;
            pend_in  = 1'b1;
            wside_in = undo_ff[0];
            if (undo_ff == '0) begin
               state_in = chi_pkg::ST_UNDO_LAST;
            end else begin
               undo_in = undo_ff - 1'b1;
            end
         end
         chi_pkg::ST_UNDO_LAST: begin
            res_in   = 1'b0;
            state_in = chi_pkg::ST_FINISH;
         end
         chi_pkg::ST_FINISH: begin
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_valid_in    = 1'b1;
               rsp_inserted_in = res_ff;
               state_in        = chi_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = chi_pkg::ST_CLEAR;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= chi_pkg::ST_CLEAR;
         clr_ff       <= '0;
         pend_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         clr_ff       <= clr_in;
         pend_ff      <= pend_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      cur_key_ff      <= cur_key_in;
      cur_idx_ff      <= cur_idx_in;
      cur_aux_ff      <= cur_aux_in;
      probe_ff        <= probe_in;
      undo_ff         <= undo_in;
      wside_ff        <= wside_in;
      res_ff          <= res_in;
      rsp_inserted_ff <= rsp_inserted_in;
   end

   assign req_ready    = (state_ff == chi_pkg::ST_IDLE);
   assign rsp_valid    = rsp_valid_ff;
   assign rsp_inserted = rsp_inserted_ff;

endmodule

FILE: rtl/chi_ram.sv
// simple dual-port synchronous ram with a registered read port
module chi_ram #(
   parameter int DEPTH = 128,
   parameter int WIDTH = 55,
   localparam int ADDR_BITS = $clog2(DEPTH)
) (
   input  logic                 clock,
   input  logic                 wr_en,
   input  logic [ADDR_BITS-1:0] wr_addr,
   input  logic [WIDTH-1:0]     wr_data,
   input  logic                 rd_en,
   input  logic [ADDR_BITS-1:0] rd_addr,
   output logic [WIDTH-1:0]     rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      // read sees the old contents on a same-cycle write
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

FILE: rtl/chi_hash.sv
// two-stage hash unit: key residues, then table indexes by exact division
module chi_hash #(
   parameter int KEY_BITS = 48,
   parameter int IDX_BITS = 7
) (
   input  logic                clock,
   input  logic [KEY_BITS-1:0] key,
   output logic [IDX_BITS-1:0] idx0,
   output logic [IDX_BITS-1:0] idx1
);

   localparam int D0 = chi_pkg::HASH0_DIGIT;
   localparam int D1 = chi_pkg::HASH1_DIGIT;
   localparam int N0 = (KEY_BITS + D0 - 1) / D0;
   localparam int N1 = (KEY_BITS + D1 - 1) / D1;
   localparam int S0_BITS = $clog2(N0 * chi_pkg::HASH0_DIV + 1);
   localparam int S1_BITS = $clog2(N1 * chi_pkg::HASH1_DIV + 1);

   logic [N0*D0-1:0]    key0_ext;
   logic [N1*D1-1:0]    key1_ext;
   logic [S0_BITS-1:0]  sum0;
   logic [S1_BITS-1:0]  sum1;
   logic [D0:0]         fold0;
   logic [D1:0]         fold1;
   logic [D0-1:0]       rem0_in, rem0_ff;
   logic [D1-1:0]       rem1_in, rem1_ff;
   logic [15:0]         diff0, diff1, quot0, quot1;
   logic [IDX_BITS-1:0] idx0_in, idx0_ff, idx1_in, idx1_ff;

   // residues: since 2^d is one more than the divisor, digits sum mod divisor
   always_comb begin
      key0_ext = (N0 * D0)'(key);
      key1_ext = (N1 * D1)'(key);
      sum0 = '0;
      sum1 = '0;
      for (int i = 0; i < N0; i++) begin
         sum0 = sum0 + S0_BITS'(key0_ext[i*D0 +: D0]);
      end
      for (int i = 0; i < N1; i++) begin
         sum1 = sum1 + S1_BITS'(key1_ext[i*D1 +: D1]);
      end
      fold0 = (D0 + 1)'(sum0 >> D0) + (D0 + 1)'(sum0[D0-1:0]);
      fold1 = (D1 + 1)'(sum1 >> D1) + (D1 + 1)'(sum1[D1-1:0]);
      if (fold0 >= (D0 + 1)'(chi_pkg::HASH0_DIV)) begin
         rem0_in = D0'(fold0 - (D0 + 1)'(chi_pkg::HASH0_DIV));
      end else begin
         rem0_in = D0'(fold0);
      end
      if (fold1 >= (D1 + 1)'(chi_pkg::HASH1_DIV)) begin
         rem1_in = D1'(fold1 - (D1 + 1)'(chi_pkg::HASH1_DIV));
      end else begin
         rem1_in = D1'(fold1);
      end
   end

   // low quotient bits: (key - residue) times the divisor's inverse
   always_comb begin
      diff0 = key[15:0] - 16'(rem0_ff);
      diff1 = key[15:0] - 16'(rem1_ff);
      quot0 = diff0 * chi_pkg::HASH0_INV;
      quot1 = diff1 * chi_pkg::HASH1_INV;
      idx0_in = quot0[IDX_BITS-1:0];
      idx1_in = key[IDX_BITS:1] + quot1[IDX_BITS-1:0];
   end

   always_ff @(posedge clock) begin
      rem0_ff <= rem0_in;
      rem1_ff <= rem1_in;
      idx0_ff <= idx0_in;
      idx1_ff <= idx1_in;
   end

   assign idx0 = idx0_ff;
   assign idx1 = idx1_ff;

endmodule

FILE: tb/cuckoo_hash_insert_test.sv
// testbench for the two-table cuckoo insert block, self-checking with a table mirror
module cuckoo_hash_insert_test;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int TABLE_DEPTH = 128;
   localparam int MAX_ROUNDS  = 10;
   localparam int KEY_BITS    = 48;

   // hash divisors of the two tables
   localparam int unsigned FIRST_DIV  = 127;
   localparam int unsigned SECOND_DIV = 255;

   localparam int RANDOM_KEYS  = 1650;
   // long receiver hold-off, started once enough keys have gone in
   localparam int HOLD_AFTER   = 400;
   localparam int HOLD_CYCLES  = 300;
   // window of random keys with no idling on either side
   localparam int CALM_FIRST   = 900;
   localparam int CALM_LAST    = 1150;
   // drain time, longer than a failed insert plus the move into the output register
   localparam int DRAIN_CYCLES = 60;
   // watchdog limit, above the slowest run of about 1670 keys plus the clearing sweep
   localparam int unsigned CYCLE_LIMIT = 400000;

   // mirror of both tables: predicts the inserted flag of every accepted key
   class cuckoo_mirror;
      logic [KEY_BITS-1:0] first_slots [TABLE_DEPTH];
      logic [KEY_BITS-1:0] second_slots [TABLE_DEPTH];
      bit expected_inserted [$];
      int mismatches;

      function new();
         foreach (first_slots[i]) begin
            first_slots[i]  = '0;
            second_slots[i] = '0;
         end
         mismatches = 0;
      endfunction

      function int unsigned slot_in_first(logic [KEY_BITS-1:0] key);
         return 32'((64'(key) / FIRST_DIV) & (TABLE_DEPTH - 1));
      endfunction

      function int unsigned slot_in_second(logic [KEY_BITS-1:0] key);
         return 32'(((64'(key) >> 1) + 64'(key) / SECOND_DIV) & (TABLE_DEPTH - 1));
      endfunction

      // run the insert on the mirror and queue the flag it should produce
      function void apply_key(logic [KEY_BITS-1:0] key);
         logic [KEY_BITS-1:0] saved_first [TABLE_DEPTH];
         logic [KEY_BITS-1:0] saved_second [TABLE_DEPTH];
         logic [KEY_BITS-1:0] moving;
         logic [KEY_BITS-1:0] evicted;
         int unsigned idx;
         if (key == '0) begin
            expected_inserted.push_back(1'b0);
            return;
         end
         saved_first  = first_slots;
         saved_second = second_slots;
         moving = key;
         for (int r = 0; r < MAX_ROUNDS; r++) begin
            for (int side = 0; side < 2; side++) begin
               if (side == 0) begin
                  idx = slot_in_first(moving);
                  evicted = first_slots[idx];
                  first_slots[idx] = moving;
               end else begin
                  idx = slot_in_second(moving);
                  evicted = second_slots[idx];
                  second_slots[idx] = moving;
               end
               if (evicted == '0) begin
                  expected_inserted.push_back(1'b1);
                  return;
               end
               moving = evicted;
            end
         end
         // no free slot: the tables go back to what they held before
         first_slots  = saved_first;
         second_slots = saved_second;
         expected_inserted.push_back(1'b0);
      endfunction

      function void check_inserted(logic actual);
         bit want;
         if (expected_inserted.size() == 0) begin
            $display("%0t: result with none expected, expected none, actual inserted=%0b",
                     $time, actual);
            mismatches++;
            return;
         end
         want = expected_inserted.pop_front();
         if (actual !== want) begin
            $display("%0t: inserted mismatch, expected %0b, actual %0b", $time, want, actual);
            mismatches++;
         end
      endfunction

      function int outstanding();
         return expected_inserted.size();
      endfunction
   endclass

   logic                clock = 1'b0;
   logic                reset = 1'b1;
   logic                req_valid = 1'b0;
   logic                req_ready;
   logic [KEY_BITS-1:0] req_key = '0;
   logic                rsp_valid;
   logic                rsp_ready = 1'b0;
   logic                rsp_inserted;

   // calm switches idling off on both sides, hold_rsp is the long hold-off
   logic calm = 1'b0;
   logic hold_rsp = 1'b0;
   int keys_sent = 0;
   int unsigned cycle_count = 0;
   logic [KEY_BITS-1:0] used_keys [$];
   cuckoo_mirror mirror;

   always begin
      #5ns clock = 1'b1;
      #5ns clock = 1'b0;
   end

   cuckoo_hash_insert #(
      .TABLE_DEPTH(TABLE_DEPTH),
      .MAX_ROUNDS (MAX_ROUNDS),
      .KEY_BITS   (KEY_BITS)
   ) i_dut (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_key     (req_key),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .rsp_inserted(rsp_inserted)
   );

   // offer one key, with random idle cycles ahead of it, and wait for its transfer
   task automatic send_key(input logic [KEY_BITS-1:0] key);
      if (!calm) begin
         while ($urandom_range(99) < 11) begin
            req_valid <= 1'b0;
            @(posedge clock);
         end
      end
      req_valid <= 1'b1;
      req_key   <= key;
      // ready is sampled as it stood just before the edge
      do @(posedge clock); while (!req_ready);
      mirror.apply_key(key);
      used_keys.push_back(key);
      keys_sent++;
   endtask

   // take results, stall at random, and check each transfer against the mirror
   task automatic collect_results();
      forever begin
         @(posedge clock);
         if (rsp_valid && rsp_ready) begin
            mirror.check_inserted(rsp_inserted);
         end
         if (hold_rsp) begin
            rsp_ready <= 1'b0;
         end else if (calm) begin
            rsp_ready <= 1'b1;
         end else begin
            rsp_ready <= ($urandom_range(99) >= 11);
         end
      end
   endtask

   // the receiver goes deaf for a long stretch while keys keep coming, so the
   // output register fills and the block has to stall its input
   task automatic hold_off_receiver();
      wait (keys_sent >= HOLD_AFTER);
      hold_rsp <= 1'b1;
      repeat (HOLD_CYCLES) @(posedge clock);
      hold_rsp <= 1'b0;
   endtask

   // watchdog
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("cuckoo_hash_insert_test NOT OK");
         $finish;
      end
   end

   initial begin
      logic [KEY_BITS-1:0] directed_keys [$];
      logic [KEY_BITS-1:0] trap_key;
      logic [KEY_BITS-1:0] key;
      logic [63:0] wide;
      int unsigned pick;

      mirror = new();

      // a third key sharing both slots of keys 2 and 3: three keys for two
      // slots, so the displacement chain can never end and the insert rolls back
      trap_key = KEY_BITS'(4);
      while (mirror.slot_in_first(trap_key) != mirror.slot_in_first(KEY_BITS'(2)) ||
             mirror.slot_in_second(trap_key) != mirror.slot_in_second(KEY_BITS'(2))) begin
         trap_key++;
      end

      // zero key, smallest and largest key, a short displacement chain, a
      // failing insert (twice), duplicates of keys already present, values
      // right at the hash divisors and assorted bit patterns
      directed_keys = '{
         '0, 48'h1, '1, 48'h2, 48'h3, trap_key, trap_key, 48'h1, '1, '0,
         48'h8000_0000_0000, 48'h7F, 48'h7E, 48'hFF, 48'hFE,
         48'h7FFF_FFFF_FFFF, 48'hAAAA_AAAA_AAAA, 48'h5555_5555_5555
      };

      // synchronous reset, released once; the block then clears its tables
      // and holds req_ready low until that sweep is done
      repeat (8) @(posedge clock);
      reset <= 1'b0;

      fork
         collect_results();
         hold_off_receiver();
      join_none

      foreach (directed_keys[i]) begin
         send_key(directed_keys[i]);
      end

      // random keys: full-width values, small values that often share slots and
      // build long chains, repeats of keys seen before, zero keys, single-bit
      // patterns and their inverses
      for (int n = 0; n < RANDOM_KEYS; n++) begin
         calm <= (n >= CALM_FIRST && n < CALM_LAST);
         wide = {$urandom(), $urandom()};
         pick = $urandom_range(99);
         if (pick < 50) begin
            key = wide[KEY_BITS-1:0];
         end else if (pick < 70) begin
            key = KEY_BITS'($urandom_range(40000, 1));
         end else if (pick < 85) begin
            key = used_keys[$urandom_range(used_keys.size() - 1)];
         end else if (pick < 90) begin
            key = '0;
         end else if (pick < 95) begin
            key = {{(KEY_BITS-1){1'b0}}, 1'b1} << $urandom_range(KEY_BITS - 1);
         end else begin
            key = ~({{(KEY_BITS-1){1'b0}}, 1'b1} << $urandom_range(KEY_BITS - 1));
         end
         send_key(key);
      end
      req_valid <= 1'b0;

      // drain every pending result, then give a stray one time to show up
      while (mirror.outstanding() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      if (mirror.mismatches == 0 && mirror.outstanding() == 0) begin
         $display("cuckoo_hash_insert_test OK");
      end else begin
         $display("cuckoo_hash_insert_test NOT OK");
      end
      $finish;
   end

endmodule
